// ----- rtl/vwdm_pkg.sv -----
// Shared types, codes and helpers of the virtual watchdog multiplexer.
`timescale 1ns / 1ps
package vwdm_pkg;

  localparam int Channels = 8;
  localparam int ChW      = 3;
  localparam int MaxRes   = 16;
  localparam int CntW     = 5;

  // Request kinds
  localparam logic [3:0] KindTick      = 4'd0;
  localparam logic [3:0] KindPat       = 4'd1;
  localparam logic [3:0] KindEnable    = 4'd2;
  localparam logic [3:0] KindDisable   = 4'd3;
  localparam logic [3:0] KindSetTimes  = 4'd4;
  localparam logic [3:0] KindSetActive = 4'd5;
  localparam logic [3:0] KindFreeze    = 4'd6;
  localparam logic [3:0] KindUnfreeze  = 4'd7;
  localparam logic [3:0] KindQuery     = 4'd8;

  // Result codes
  localparam logic [2:0] ResDone  = 3'd0;
  localparam logic [2:0] ResBark  = 3'd1;
  localparam logic [2:0] ResBite  = 3'd2;
  localparam logic [2:0] ResAbort = 3'd3;
  localparam logic [2:0] ResBusy  = 3'd4;

  // Register indexes
  localparam logic [2:0] RegTicksPerMs    = 3'd0;
  localparam logic [2:0] RegLatencyMargin = 3'd1;
  localparam logic [2:0] RegMaxTimeoutMs  = 3'd2;
  localparam logic [2:0] RegReservedMs    = 3'd3;
  localparam logic [2:0] RegCriticalMask  = 3'd4;

  localparam logic [19:0] RstTicksPerMs    = 20'd19200;
  localparam logic [15:0] RstLatencyMargin = 16'd16;
  localparam logic [31:0] RstMaxTimeoutMs  = 32'd60000;
  localparam logic [31:0] RstReservedMs    = 32'hFFFF_FFFE;
  localparam logic [7:0]  RstCriticalMask  = 8'd0;

  localparam logic [7:0] FreezeMax = 8'hFF;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  channel;
    logic        change_bark;
    logic        change_bite;
    logic [31:0] bark_ms;
    logic [31:0] bite_ms;
    logic        reset_on_freeze;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  event_channel;
    logic        changed;
    logic        is_enabled;
    logic        is_expired;
    logic [31:0] ms_since_pat;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [19:0] ticks_per_ms;
    logic [15:0] latency_margin;
    logic [31:0] max_timeout_ms;
    logic [31:0] reserved_ms;
    logic [7:0]  critical_mask;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LATCH, CMD_PRE, CMD_MUL_BARK, CMD_MUL_BITE,
    CMD_U1, CMD_U2, CMD_U3, CMD_U4, CMD_DIV_START, CMD_OP_EMIT,
    CMD_TICK_INC, CMD_LIM, CMD_SCAN_INIT, CMD_SCAN_STEP, CMD_SEL,
    CMD_HADD, CMD_REARM, CMD_BITE, CMD_BARK, CMD_FINISH
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_query;
    logic upd;
    logic scan_last;
    logic found;
    logic act_bite;
    logic bite_due;
    logic crit;
    logic room;
    logic div_busy;
    logic out_free;
  } sts_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_PRE, S_MULA, S_MULB, S_U1, S_U2, S_U3, S_U4,
    S_DIV, S_DIVW, S_EMIT, S_TINC, S_LIM, S_SCAN0, S_SCAN, S_PICK,
    S_HCHK, S_HMUL, S_HADD, S_HCMP, S_BITE, S_BITE_B, S_BARK, S_CHK, S_FIN
  } state_e;

  function automatic logic [31:0] sat_ms(input logic [31:0] v, input logic [31:0] cap);
    return (v < cap) ? v : cap;
  endfunction

endpackage

// ----- rtl/vwdm_div.sv -----
// Iterative restoring divider: 64-bit dividend by 20-bit divisor, one bit a cycle.
`timescale 1ns / 1ps
module vwdm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [19:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);
  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [19:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [63:0] quo_q, quo_d;
  logic [20:0] trial;
  logic        ge;

  assign trial = {rem_q, quo_q[63]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd63;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? 20'(trial - {1'b0, dvs_q}) : 20'(trial);
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;
endmodule

// ----- rtl/vwdm_dp.sv -----
// Datapath: channel state, shared multiplier, scan, divider and result staging.
`timescale 1ns / 1ps
module vwdm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vwdm_pkg::cfg_t      cfg_i,
  input  vwdm_pkg::in_item_t  in_data_i,
  input  vwdm_pkg::cmd_t      cmd_i,
  output vwdm_pkg::sts_t      sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output vwdm_pkg::out_item_t out_data_o
);
  import vwdm_pkg::*;

  in_item_t        op_q;
  logic [ChW-1:0]  ch_q, best_q;
  logic            en_q   [Channels];
  logic            was_q  [Channels];
  logic [7:0]      fc_q   [Channels];
  logic [31:0]     bark_q [Channels];
  logic [31:0]     bite_q [Channels];
  logic [1:0]      ts_q   [Channels];
  logic [63:0]     lp_q   [Channels];
  logic [63:0]     dl_q   [Channels];
  logic            dlv_q  [Channels];
  logic            ab_q   [Channels];
  logic [63:0]     rem_q  [Channels];
  logic            remv_q [Channels];
  logic [63:0]     now_q, lim_q, best_dl_q;
  logic [CntW-1:0] cnt_q;
  logic [2:0]      res_q;
  logic            chg_q, upd_q, pat_q, found_q;
  logic [51:0]     bark_t_q, bite_t_q;
  logic [63:0]     diff_q, bark_dl_q, bite_dl_q;
  out_item_t       pend_q, out_q;
  logic            pend_v_q, out_v_q;

  // current channel view
  logic        c_en, c_was, c_dlv, c_ab, c_remv;
  logic [7:0]  c_fc;
  logic [31:0] c_bark, c_bite;
  logic [1:0]  c_ts;
  logic [63:0] c_lp, c_dl, c_rem;

  assign c_en   = en_q[ch_q];
  assign c_was  = was_q[ch_q];
  assign c_fc   = fc_q[ch_q];
  assign c_bark = bark_q[ch_q];
  assign c_bite = bite_q[ch_q];
  assign c_ts   = ts_q[ch_q];
  assign c_lp   = lp_q[ch_q];
  assign c_dl   = dl_q[ch_q];
  assign c_dlv  = dlv_q[ch_q];
  assign c_ab   = ab_q[ch_q];
  assign c_rem  = rem_q[ch_q];
  assign c_remv = remv_q[ch_q];

  logic [19:0] tpm;
  logic [31:0] mul_a;
  logic [51:0] prod;
  assign tpm   = (cfg_i.ticks_per_ms == '0) ? 20'd1 : cfg_i.ticks_per_ms;
  assign mul_a = (cmd_i.op == CMD_MUL_BARK) ? c_bark : c_bite;
  assign prod  = 52'(mul_a) * 52'(tpm);

  logic        div_busy;
  logic [63:0] quot;
  vwdm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == CMD_DIV_START),
    .dividend_i (now_q - c_lp),
    .divisor_i  (tpm),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // per-request state update of the addressed channel
  logic        p_en, p_was, p_dlv, p_remv, p_chg, p_upd, p_pat, e_req;
  logic [7:0]  p_fc;
  logic [31:0] p_bark, p_bite;
  logic [1:0]  p_ts;
  logic [63:0] p_rem;
  logic [2:0]  p_res;

  always_comb begin
    p_en = c_en; p_was = c_was; p_fc = c_fc; p_bark = c_bark; p_bite = c_bite;
    p_ts = c_ts; p_rem = c_rem; p_remv = c_remv; p_dlv = c_dlv;
    p_res = ResDone; p_chg = 1'b0; p_upd = 1'b0; p_pat = 1'b0;
    e_req = (op_q.kind == KindEnable);
    case (op_q.kind)
      KindPat: begin
        p_remv = 1'b0;
        if (c_en) begin
          p_upd = 1'b1;
          p_pat = 1'b1;
        end
      end
      KindEnable, KindDisable: begin
        if (c_fc == 8'd0) begin
          if (c_en != e_req) begin
            if (e_req) begin
              if (!c_ts[0]) p_bark = cfg_i.max_timeout_ms;
              if (!c_ts[1]) p_bite = cfg_i.max_timeout_ms;
              p_ts  = 2'b11;
              p_en  = 1'b1;
              p_upd = 1'b1;
            end else begin
              p_en   = 1'b0;
              p_rem  = c_dl - now_q;
              p_remv = c_dlv;
              p_dlv  = 1'b0;
            end
          end
        end else begin
          if (e_req && !c_was) begin
            if (!c_ts[0]) p_bark = cfg_i.max_timeout_ms;
            if (!c_ts[1]) p_bite = cfg_i.max_timeout_ms;
            p_ts = 2'b11;
          end
          p_was = e_req;
        end
      end
      KindSetTimes: begin
        if (op_q.change_bark) begin
          p_bark  = sat_ms(op_q.bark_ms, cfg_i.reserved_ms);
          p_ts[0] = 1'b1;
        end
        if (op_q.change_bite) begin
          p_bite  = sat_ms(op_q.bite_ms, cfg_i.reserved_ms);
          p_ts[1] = 1'b1;
        end
        if (op_q.change_bark || op_q.change_bite) begin
          p_chg  = 1'b1;
          p_remv = 1'b0;
          p_upd  = c_en;
        end
      end
      KindSetActive: begin
        if (c_ab) begin
          p_bite  = sat_ms(op_q.bark_ms, cfg_i.reserved_ms);
          p_ts[1] = 1'b1;
        end else begin
          p_bark  = sat_ms(op_q.bark_ms, cfg_i.reserved_ms);
          p_ts[0] = 1'b1;
        end
        p_chg  = 1'b1;
        p_remv = 1'b0;
        p_upd  = c_en;
      end
      KindFreeze: begin
        if (c_fc == FreezeMax) begin
          p_res = ResBusy;
        end else begin
          if (c_fc == 8'd0) begin
            p_was = c_en;
            if (c_en) begin
              p_en   = 1'b0;
              p_rem  = c_dl - now_q;
              p_remv = c_dlv;
              p_dlv  = 1'b0;
            end
          end
          if (op_q.reset_on_freeze) p_remv = 1'b0;
          p_fc = c_fc + 8'd1;
        end
      end
      KindUnfreeze: begin
        if (c_fc == 8'd0) begin
          p_res = ResBusy;
        end else begin
          p_fc = c_fc - 8'd1;
          // wake from the last unfreeze re-enables
          if (c_fc == 8'd1 && c_was && !c_en) begin
            if (!c_ts[0]) p_bark = cfg_i.max_timeout_ms;
            if (!c_ts[1]) p_bite = cfg_i.max_timeout_ms;
            p_ts  = 2'b11;
            p_en  = 1'b1;
            p_upd = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  logic [63:0] lp_new;
  always_comb begin
    lp_new = c_lp;
    if (pat_q) lp_new = now_q;
    else if (!c_dlv) lp_new = c_remv ? (now_q - diff_q) : now_q;
  end

  logic [64:0] lim_sum;
  logic        cand, crit, is_produce;
  assign lim_sum = {1'b0, now_q} + 65'(cfg_i.latency_margin);
  assign cand    = c_dlv && (c_dl <= lim_q) && (!found_q || (c_dl < best_dl_q));
  assign crit    = cfg_i.critical_mask[ch_q];

  out_item_t new_item;
  always_comb begin
    new_item = '0;
    new_item.event_channel = ch_q;
    is_produce = 1'b0;
    case (cmd_i.op)
      CMD_OP_EMIT: begin
        is_produce = 1'b1;
        new_item.event_res = res_q;
        new_item.changed   = chg_q;
        if (op_q.kind == KindQuery) begin
          new_item.is_enabled   = c_en;
          new_item.is_expired   = c_en && c_ab;
          new_item.ms_since_pat = (quot[63:32] != '0) ? 32'hFFFF_FFFF : quot[31:0];
        end
      end
      CMD_BITE: begin
        is_produce = 1'b1;
        new_item.event_res = crit ? ResAbort : ResBite;
      end
      CMD_BARK: begin
        is_produce = 1'b1;
        new_item.event_res = ResBark;
      end
      default: ;
    endcase
  end

  // final result of a request: the staged one, or an empty done
  out_item_t fin_item;
  always_comb begin
    fin_item      = pend_v_q ? pend_q : '0;
    fin_item.last = 1'b1;
  end

  logic out_free;
  assign out_free = !out_v_q || !out_stall_i;

  // channel state and control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        en_q[i] <= 1'b0; was_q[i] <= 1'b0; fc_q[i] <= '0; bark_q[i] <= '0;
        bite_q[i] <= '0; ts_q[i] <= '0; lp_q[i] <= '0; dl_q[i] <= '0;
        dlv_q[i] <= 1'b0; ab_q[i] <= 1'b0; rem_q[i] <= '0; remv_q[i] <= 1'b0;
      end
      now_q    <= '0;
      ch_q     <= '0;
      cnt_q    <= '0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      case (cmd_i.op)
        CMD_LATCH: begin
          ch_q  <= in_data_i.channel;
          cnt_q <= '0;
        end
        CMD_PRE: begin
          en_q[ch_q] <= p_en; was_q[ch_q] <= p_was; fc_q[ch_q] <= p_fc;
          bark_q[ch_q] <= p_bark; bite_q[ch_q] <= p_bite; ts_q[ch_q] <= p_ts;
          rem_q[ch_q] <= p_rem; remv_q[ch_q] <= p_remv; dlv_q[ch_q] <= p_dlv;
        end
        CMD_U2: lp_q[ch_q] <= lp_new;
        CMD_U4: begin
          dlv_q[ch_q] <= 1'b1;
          if (bite_dl_q <= bark_dl_q) begin
            dl_q[ch_q] <= bite_dl_q;
            ab_q[ch_q] <= 1'b1;
          end else begin
            dl_q[ch_q] <= bark_dl_q;
            ab_q[ch_q] <= 1'b0;
          end
        end
        CMD_TICK_INC: now_q <= now_q + 64'd1;
        CMD_SCAN_INIT: begin
          ch_q    <= '0;
          found_q <= 1'b0;
        end
        CMD_SCAN_STEP: begin
          if (cand) found_q <= 1'b1;
          ch_q <= ch_q + ChW'(1);
        end
        CMD_SEL: ch_q <= best_q;
        CMD_REARM: begin
          dl_q[ch_q] <= bite_dl_q;
          ab_q[ch_q] <= 1'b1;
        end
        CMD_BITE: begin
          dlv_q[ch_q] <= 1'b0;
          en_q[ch_q]  <= 1'b0;
        end
        default: ;
      endcase

      if (is_produce) begin
        pend_v_q <= 1'b1;
        cnt_q    <= cnt_q + CntW'(1);
      end else if (cmd_i.op == CMD_FINISH) begin
        pend_v_q <= 1'b0;
      end

      if (cmd_i.op == CMD_FINISH || (is_produce && pend_v_q)) out_v_q <= 1'b1;
      else if (!out_stall_i) out_v_q <= 1'b0;
    end
  end

  // scratch and payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LATCH: begin
        op_q  <= in_data_i;
        res_q <= ResDone;
        chg_q <= 1'b0;
        upd_q <= 1'b0;
        pat_q <= 1'b0;
      end
      CMD_PRE: begin
        res_q <= p_res;
        chg_q <= p_chg;
        upd_q <= p_upd;
        pat_q <= p_pat;
      end
      CMD_MUL_BARK: bark_t_q <= prod;
      CMD_MUL_BITE: bite_t_q <= prod;
      CMD_U1: diff_q <= (c_ab ? 64'(bite_t_q) : 64'(bark_t_q)) - c_rem;
      CMD_U3: begin
        bark_dl_q <= c_lp + 64'(bark_t_q);
        bite_dl_q <= c_lp + 64'(bite_t_q);
      end
      CMD_LIM: lim_q <= lim_sum[64] ? '1 : lim_sum[63:0];
      CMD_SCAN_STEP: begin
        if (cand) begin
          best_q    <= ch_q;
          best_dl_q <= c_dl;
        end
      end
      CMD_HADD: bite_dl_q <= c_lp + 64'(bite_t_q);
      default: ;
    endcase

    if (is_produce) pend_q <= new_item;

    if (cmd_i.op == CMD_FINISH) begin
      out_q <= fin_item;
    end else if (is_produce && pend_v_q) begin
      out_q <= pend_q;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.is_tick   = (op_q.kind == KindTick);
    sts_o.is_query  = (op_q.kind == KindQuery);
    sts_o.upd       = upd_q;
    sts_o.scan_last = (ch_q == ChW'(Channels - 1));
    sts_o.found     = found_q;
    sts_o.act_bite  = c_ab;
    sts_o.bite_due  = (bite_dl_q <= lim_q);
    sts_o.crit      = crit;
    sts_o.room      = (cnt_q <= CntW'(MaxRes - 2));
    sts_o.div_busy  = div_busy;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRes))
    else $error("result count beyond limit");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_FINISH || (is_produce && pend_v_q)) |-> out_free)
    else $error("result register overwritten");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_FINISH) |=> (!pend_v_q && out_v_q && out_q.last))
    else $error("finish did not flush the staged result");
endmodule

// ----- rtl/vwdm_ctrl.sv -----
// Controller state machine sequencing the datapath for each request.
`timescale 1ns / 1ps
module vwdm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vwdm_pkg::sts_t sts_i,
  output vwdm_pkg::cmd_t cmd_o
);
  import vwdm_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (sts_i.is_tick) state_d = S_TINC;
        else if (sts_i.is_query) state_d = S_DIV;
        else state_d = S_PRE;
      end
      S_PRE:      state_d = S_MULA;
      S_MULA:     state_d = S_MULB;
      S_MULB:     state_d = sts_i.upd ? S_U1 : S_EMIT;
      S_U1:       state_d = S_U2;
      S_U2:       state_d = S_U3;
      S_U3:       state_d = S_U4;
      S_U4:       state_d = S_EMIT;
      S_DIV:      state_d = S_DIVW;
      S_DIVW:     if (!sts_i.div_busy) state_d = S_EMIT;
      S_EMIT:     if (sts_i.out_free) state_d = S_FIN;
      S_TINC:     state_d = S_LIM;
      S_LIM:      state_d = S_SCAN0;
      S_SCAN0:    state_d = S_SCAN;
      S_SCAN:     if (sts_i.scan_last) state_d = S_PICK;
      S_PICK:     state_d = sts_i.found ? S_HCHK : S_FIN;
      S_HCHK:     state_d = sts_i.act_bite ? S_BITE : S_HMUL;
      S_HMUL:     state_d = S_HADD;
      S_HADD:     state_d = S_HCMP;
      S_HCMP:     state_d = sts_i.bite_due ? S_BITE_B : S_BARK;
      S_BITE:     if (sts_i.out_free) state_d = S_CHK;
      S_BITE_B:   if (sts_i.out_free) state_d = sts_i.crit ? S_CHK : S_BARK;
      S_BARK:     if (sts_i.out_free) state_d = S_CHK;
      S_CHK:      state_d = sts_i.room ? S_SCAN0 : S_FIN;
      S_FIN:      if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = CMD_NONE;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) cmd_o.op = CMD_LATCH;
      S_PRE:    cmd_o.op = CMD_PRE;
      S_MULA:   cmd_o.op = CMD_MUL_BARK;
      S_MULB:   cmd_o.op = CMD_MUL_BITE;
      S_U1:     cmd_o.op = CMD_U1;
      S_U2:     cmd_o.op = CMD_U2;
      S_U3:     cmd_o.op = CMD_U3;
      S_U4:     cmd_o.op = CMD_U4;
      S_DIV:    cmd_o.op = CMD_DIV_START;
      S_EMIT:   if (sts_i.out_free) cmd_o.op = CMD_OP_EMIT;
      S_TINC:   cmd_o.op = CMD_TICK_INC;
      S_LIM:    cmd_o.op = CMD_LIM;
      S_SCAN0:  cmd_o.op = CMD_SCAN_INIT;
      S_SCAN:   cmd_o.op = CMD_SCAN_STEP;
      S_PICK:   if (sts_i.found) cmd_o.op = CMD_SEL;
      S_HMUL:   cmd_o.op = CMD_MUL_BITE;
      S_HADD:   cmd_o.op = CMD_HADD;
      S_HCMP:   if (!sts_i.bite_due) cmd_o.op = CMD_REARM;
      S_BITE, S_BITE_B: if (sts_i.out_free) cmd_o.op = CMD_BITE;
      S_BARK:   if (sts_i.out_free) cmd_o.op = CMD_BARK;
      S_FIN:    if (sts_i.out_free) cmd_o.op = CMD_FINISH;
      default:  cmd_o.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_stall_o = (state_q != S_IDLE);
endmodule

// ----- rtl/virtual_watchdog_multiplexer.sv -----
// Top level: configuration registers, controller and datapath.
`timescale 1ns / 1ps
// Virtual watchdog multiplexer, eight channels.
// Requests arrive on in_valid_i/in_stall_o with an in_item_t payload and are
// taken one at a time; results leave on out_valid_o/out_stall_i, one
// out_item_t each, the final result of a request flagged by last.
// Each result is staged one step behind, so last is known when it is shown.
// Pat, enable, disable, set times, freeze, unfreeze and unknown kinds pass
// through the shared 32x20 multiplier and re-arm the channel when an update
// is due. A query waits for the one-bit-a-cycle divider that turns elapsed
// ticks into milliseconds. A tick handles due channels one at a time and
// rescans after each; each pass scans the eight deadlines one a cycle
// through a single state read port. A tick gives at most 16 results;
// channels still due wait for the next tick.
// Reset clears all channel state, the tick counter and the output valid flag,
// and loads the configuration defaults. Configuration is written over the APB
// port; the user must write it only while no request is in flight, which the
// block does not enforce. While the receiver stalls, the result register
// holds and the block waits.
module virtual_watchdog_multiplexer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  vwdm_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output vwdm_pkg::out_item_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import vwdm_pkg::*;

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;
  cmd_t       cmd;
  sts_t       sts;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_ms   <= RstTicksPerMs;
      cfg_q.latency_margin <= RstLatencyMargin;
      cfg_q.max_timeout_ms <= RstMaxTimeoutMs;
      cfg_q.reserved_ms    <= RstReservedMs;
      cfg_q.critical_mask  <= RstCriticalMask;
    end else if (wr_en) begin
      case (reg_idx)
        RegTicksPerMs:    cfg_q.ticks_per_ms   <= pwdata[19:0];
        RegLatencyMargin: cfg_q.latency_margin <= pwdata[15:0];
        RegMaxTimeoutMs:  cfg_q.max_timeout_ms <= pwdata;
        RegReservedMs:    cfg_q.reserved_ms    <= pwdata;
        RegCriticalMask:  cfg_q.critical_mask  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTicksPerMs:    prdata = 32'(cfg_q.ticks_per_ms);
      RegLatencyMargin: prdata = 32'(cfg_q.latency_margin);
      RegMaxTimeoutMs:  prdata = cfg_q.max_timeout_ms;
      RegReservedMs:    prdata = cfg_q.reserved_ms;
      RegCriticalMask:  prdata = 32'(cfg_q.critical_mask);
      default:          prdata = '0;
    endcase
  end

  vwdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vwdm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );
endmodule
